### design/argb_pkg.sv
// Shared types and constants for the ARGB to semi-planar YUV 4:2:0 converter.
`timescale 1ns / 1ps
`default_nettype none

package argb_pkg;

  // Frame size limits
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  // Configuration port
  localparam int CFG_W     = 12;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
  localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;

  // Counter and dimension widths
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);

  typedef logic [WDIM_W-1:0]        wdim_t;
  typedef logic [HDIM_W-1:0]        hdim_t;
  typedef logic [WDIM_W+HDIM_W-1:0] area_t;

  // Addresses
  localparam int PLANE_ADDR_W = 22;
  localparam int BYTE_ADDR_W  = 23;
  typedef logic [PLANE_ADDR_W-1:0] plane_addr_t;
  typedef logic [BYTE_ADDR_W-1:0]  byte_addr_t;

  // Component codes
  localparam logic [1:0] COMP_Y = 2'd0;
  localparam logic [1:0] COMP_V = 2'd1;
  localparam logic [1:0] COMP_U = 2'd2;

  // BT.601 integer coefficients; sums are kept in 17 bits
  typedef logic [16:0] sum_t;
  localparam sum_t K_YR = 17'd66;
  localparam sum_t K_YG = 17'd129;
  localparam sum_t K_YB = 17'd25;
  localparam sum_t K_UR = 17'd38;
  localparam sum_t K_UG = 17'd74;
  localparam sum_t K_UB = 17'd112;
  localparam sum_t K_VR = 17'd112;
  localparam sum_t K_VG = 17'd94;
  localparam sum_t K_VB = 17'd18;
  localparam sum_t ROUND      = 17'd128;
  localparam sum_t CHROMA_BIAS = 17'd32896;  // rounding plus 128 << 8
  localparam logic [7:0] LUMA_OFFSET = 8'd16;

  // Queue between the front and back ends
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    plane_addr_t luma_addr;
    plane_addr_t v_offset;
    plane_addr_t u_offset;
    logic        chroma;
    logic        frame_end;
  } q_entry_t;

endpackage

`default_nettype wire

### design/argb_fifo.sv
// Small register queue between the pixel front end and the byte back end.
`timescale 1ns / 1ps
`default_nettype none

module argb_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire argb_pkg::q_entry_t push_data,
  output logic                    full,
  input  wire logic               pop,
  output logic                    head_valid,
  output argb_pkg::q_entry_t      head_data
);

  argb_pkg::q_entry_t                entries [argb_pkg::QDEPTH];
  logic [argb_pkg::QPTR_W-1:0]       wr_ptr;
  logic [argb_pkg::QPTR_W-1:0]       rd_ptr;
  logic [argb_pkg::QCNT_W-1:0]       count;

  assign full       = (count == argb_pkg::QCNT_W'(argb_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### design/argb_front.sv
// Front end: frame registers, raster counters and per-pixel address classification.
`timescale 1ns / 1ps
`default_nettype none

module argb_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [argb_pkg::REG_IDX_W-1:0]     cfg_index,
  input  wire logic [argb_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                               accept,
  input  wire logic [31:0]                        argb_word,
  output argb_pkg::q_entry_t                      entry,
  output argb_pkg::byte_addr_t                    chroma_base
);

  logic [argb_pkg::CFG_W-1:0] frame_width;
  logic [argb_pkg::CFG_W-1:0] frame_height;
  logic [argb_pkg::COL_W-1:0] column_count;
  logic [argb_pkg::ROW_W-1:0] row_count;
  argb_pkg::plane_addr_t      luma_address;
  argb_pkg::plane_addr_t      chroma_offset;

  argb_pkg::wdim_t            eff_w;
  argb_pkg::wdim_t            clamp_w;
  argb_pkg::hdim_t            eff_h;
  argb_pkg::area_t            area;
  logic [argb_pkg::COL_W:0]   col_p1;
  logic [argb_pkg::ROW_W:0]   row_p1;
  logic                       row_end;
  logic                       frame_end;
  logic                       chroma;
  argb_pkg::plane_addr_t      offset_p1;

  // Clamp the programmed size into range; width is forced even
  always_comb begin
    if (frame_width < 12'd2) begin
      clamp_w = argb_pkg::wdim_t'(2);
    end else if (32'(frame_width) > argb_pkg::MAX_WIDTH) begin
      clamp_w = argb_pkg::wdim_t'(argb_pkg::MAX_WIDTH);
    end else begin
      clamp_w = argb_pkg::wdim_t'(frame_width);
    end
    eff_w = clamp_w & ~argb_pkg::wdim_t'(1);

    if (frame_height == '0) begin
      eff_h = argb_pkg::hdim_t'(1);
    end else if (32'(frame_height) > argb_pkg::MAX_HEIGHT) begin
      eff_h = argb_pkg::hdim_t'(argb_pkg::MAX_HEIGHT);
    end else begin
      eff_h = argb_pkg::hdim_t'(frame_height);
    end

    area = eff_w * eff_h;
  end

  assign col_p1    = {1'b0, column_count} + 1'b1;
  assign row_p1    = {1'b0, row_count} + 1'b1;
  assign row_end   = (col_p1 >= eff_w);
  assign frame_end = row_end && (row_p1 >= eff_h);
  assign chroma    = !row_count[0] && !column_count[0];
  assign offset_p1 = chroma_offset + 1'b1;

  always_comb begin
    entry.red       = argb_word[23:16];
    entry.green     = argb_word[15:8];
    entry.blue      = argb_word[7:0];
    entry.luma_addr = luma_address;
    entry.v_offset  = chroma_offset;
    entry.u_offset  = offset_p1;
    entry.chroma    = chroma;
    entry.frame_end = frame_end;
  end

  // Chroma plane base, registered from the frame area; only read by the back end
  always_ff @(posedge clk) begin
    chroma_base <= argb_pkg::byte_addr_t'(area);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= argb_pkg::RESET_WIDTH;
      frame_height <= argb_pkg::RESET_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        argb_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        argb_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      luma_address  <= '0;
      chroma_offset <= '0;
    end else if (accept) begin
      if (frame_end) begin
        column_count  <= '0;
        row_count     <= '0;
        luma_address  <= '0;
        chroma_offset <= '0;
      end else begin
        luma_address <= luma_address + 1'b1;
        if (chroma) begin
          chroma_offset <= offset_p1 + 1'b1;
        end
        if (row_end) begin
          column_count <= '0;
          row_count    <= row_p1[argb_pkg::ROW_W-1:0];
        end else begin
          column_count <= col_p1[argb_pkg::COL_W-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

### design/argb_back.sv
// Back end: color conversion and byte sequencing into the output register.
`timescale 1ns / 1ps
`default_nettype none

module argb_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  head_valid,
  input  wire argb_pkg::q_entry_t    head_data,
  input  wire argb_pkg::byte_addr_t  chroma_base,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 component,
  output argb_pkg::byte_addr_t       byte_address,
  output logic [7:0]                 byte_value,
  output logic                       last_of_pixel,
  output logic                       last_of_frame
);

  argb_pkg::sum_t        r17;
  argb_pkg::sum_t        g17;
  argb_pkg::sum_t        b17;
  argb_pkg::sum_t        y_sum;
  argb_pkg::sum_t        u_sum;
  argb_pkg::sum_t        v_sum;

  logic                  work_valid;
  logic [1:0]            phase;
  logic [1:0]            phase_next;
  logic [7:0]            work_y;
  logic [7:0]            work_u;
  logic [7:0]            work_v;
  argb_pkg::byte_addr_t  work_luma_addr;
  argb_pkg::byte_addr_t  work_v_addr;
  argb_pkg::byte_addr_t  work_u_addr;
  logic                  work_chroma;
  logic                  work_frame_end;

  logic                  out_free;
  logic                  emit;
  logic                  done;

  // Sums stay within 0..65535 for any input, so bits 15:8 are already saturated
  always_comb begin
    r17   = argb_pkg::sum_t'(head_data.red);
    g17   = argb_pkg::sum_t'(head_data.green);
    b17   = argb_pkg::sum_t'(head_data.blue);
    y_sum = argb_pkg::K_YR * r17 + argb_pkg::K_YG * g17 + argb_pkg::K_YB * b17
            + argb_pkg::ROUND;
    u_sum = argb_pkg::K_UB * b17 + argb_pkg::CHROMA_BIAS
            - argb_pkg::K_UR * r17 - argb_pkg::K_UG * g17;
    v_sum = argb_pkg::K_VR * r17 + argb_pkg::CHROMA_BIAS
            - argb_pkg::K_VG * g17 - argb_pkg::K_VB * b17;
  end

  assign out_free = !out_valid || !out_stall;
  assign emit     = work_valid && out_free;
  assign done     = emit && ((phase == argb_pkg::COMP_U) ||
                             ((phase == argb_pkg::COMP_Y) && !work_chroma));
  assign pop      = head_valid && (!work_valid || done);

  always_comb begin
    unique case (phase)
      argb_pkg::COMP_Y: phase_next = argb_pkg::COMP_V;
      argb_pkg::COMP_V: phase_next = argb_pkg::COMP_U;
      default:          phase_next = argb_pkg::COMP_Y;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
      phase      <= argb_pkg::COMP_Y;
    end else if (pop) begin
      work_valid <= 1'b1;
      phase      <= argb_pkg::COMP_Y;
    end else if (done) begin
      work_valid <= 1'b0;
    end else if (emit) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work_y         <= y_sum[15:8] + argb_pkg::LUMA_OFFSET;
      work_u         <= u_sum[15:8];
      work_v         <= v_sum[15:8];
      work_luma_addr <= argb_pkg::byte_addr_t'(head_data.luma_addr);
      work_v_addr    <= chroma_base + argb_pkg::byte_addr_t'(head_data.v_offset);
      work_u_addr    <= chroma_base + argb_pkg::byte_addr_t'(head_data.u_offset);
      work_chroma    <= head_data.chroma;
      work_frame_end <= head_data.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= work_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      component <= phase;
      case (phase)
        argb_pkg::COMP_Y: begin
          byte_address  <= work_luma_addr;
          byte_value    <= work_y;
          last_of_pixel <= !work_chroma;
          last_of_frame <= work_frame_end && !work_chroma;
        end
        argb_pkg::COMP_V: begin
          byte_address  <= work_v_addr;
          byte_value    <= work_v;
          last_of_pixel <= 1'b0;
          last_of_frame <= 1'b0;
        end
        default: begin
          byte_address  <= work_u_addr;
          byte_value    <= work_u;
          last_of_pixel <= 1'b1;
          last_of_frame <= work_frame_end;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### design/argb_to_yuv420_semiplanar_core.sv
// Top level of the ARGB to semi-planar YUV 4:2:0 (V before U) converter.
`timescale 1ns / 1ps
`default_nettype none

// Takes one ARGB pixel per transfer in raster order and emits one byte per
// transfer: the BT.601 luma byte at its luma-plane address, and for pixels on
// an even row and even column a V byte and a U byte after it, in the
// interleaved chroma plane that starts at width*height. A pixel yields one
// output byte if it yields only luma and three bytes otherwise; the one-byte
// output register holds one byte at a time. The front end accepts a pixel
// every cycle while its four-entry queue has room, so input and output stall
// independently. With the queue empty and the back end idle, the first output
// byte passes from the queue entry through the work registers into the output
// register. Frame width and height are to be taken on the write port only
// while no pixel is in flight; the block itself does not enforce this.

module argb_to_yuv420_semiplanar_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [argb_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [argb_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [31:0]                    argb_word,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          component,
  output logic [argb_pkg::BYTE_ADDR_W-1:0]    byte_address,
  output logic [7:0]                          byte_value,
  output logic                                last_of_pixel,
  output logic                                last_of_frame
);

  argb_pkg::q_entry_t   push_entry;
  argb_pkg::q_entry_t   head_entry;
  argb_pkg::byte_addr_t chroma_base;
  logic                 queue_full;
  logic                 head_valid;
  logic                 pop;
  logic                 accept;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;

  argb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .argb_word   (argb_word),
    .entry       (push_entry),
    .chroma_base (chroma_base)
  );

  argb_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_entry)
  );

  argb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_data     (head_entry),
    .chroma_base   (chroma_base),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .component     (component),
    .byte_address  (byte_address),
    .byte_value    (byte_value),
    .last_of_pixel (last_of_pixel),
    .last_of_frame (last_of_frame)
  );

endmodule

`default_nettype wire

### dv/tb_argb_to_yuv420_semiplanar_core.sv
// Testbench for the ARGB to semi-planar YUV 4:2:0 converter with a predicting byte checker.
`timescale 1ns / 1ps

module tb_argb_to_yuv420_semiplanar_core;
  import argb_pkg::*;

  typedef struct packed {
    logic [1:0] comp;
    byte_addr_t addr;
    logic [7:0] value;
    logic       pixel_end;
    logic       frame_end;
  } yuv_byte_t;

  // Predicts the byte stream of each pixel and checks it against the output.
  class nv21_byte_checker;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [10:0]      col;
    logic [10:0]      row;
    plane_addr_t      luma_addr;
    plane_addr_t      chroma_off;
    yuv_byte_t        pending_bytes[$];
    int               mismatches;

    function new();
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      col        = '0;
      row        = '0;
      luma_addr  = '0;
      chroma_off = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_FRAME_WIDTH) width_reg = data;
      else if (idx == REG_FRAME_HEIGHT) height_reg = data;
    endfunction

    function logic [7:0] clamp_byte(int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
    endfunction

    function void take_pixel(logic [31:0] px);
      int        w;
      int        h;
      int        r;
      int        g;
      int        b;
      int        y;
      int        u;
      int        v;
      bit        row_end;
      bit        frame_end;
      bit        chroma;
      int        base;
      yuv_byte_t e;
      w = width_reg;
      if (w < 2) w = 2;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      w = w - (w % 2);
      h = height_reg;
      if (h < 1) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      r = px[23:16];
      g = px[15:8];
      b = px[7:0];
      y = ((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16;
      u = (-38 * r - 74 * g + 112 * b + 32896) >>> 8;
      v = (112 * r - 94 * g - 18 * b + 32896) >>> 8;
      row_end   = (int'(col) + 1) >= w;
      frame_end = row_end && ((int'(row) + 1) >= h);
      chroma    = !row[0] && !col[0];
      base      = w * h;

      e = '{comp: COMP_Y, addr: byte_addr_t'(luma_addr), value: clamp_byte(y),
            pixel_end: !chroma, frame_end: frame_end && !chroma};
      pending_bytes.push_back(e);
      luma_addr++;
      if (chroma) begin
        e = '{comp: COMP_V, addr: byte_addr_t'(base + int'(chroma_off)),
              value: clamp_byte(v), pixel_end: 1'b0, frame_end: 1'b0};
        pending_bytes.push_back(e);
        chroma_off++;
        e = '{comp: COMP_U, addr: byte_addr_t'(base + int'(chroma_off)),
              value: clamp_byte(u), pixel_end: 1'b1, frame_end: frame_end};
        pending_bytes.push_back(e);
        chroma_off++;
      end

      if (frame_end) begin
        col        = '0;
        row        = '0;
        luma_addr  = '0;
        chroma_off = '0;
      end else if (row_end) begin
        col = '0;
        row++;
      end else begin
        col++;
      end
    endfunction

    function void check_byte(yuv_byte_t got);
      yuv_byte_t e;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, got comp %0d addr %0d value %0d",
                 $time, got.comp, got.addr, got.value);
        mismatches++;
        return;
      end
      e = pending_bytes.pop_front();
      if (got.comp !== e.comp) begin
        $display("%0t: component expected %0d got %0d", $time, e.comp, got.comp);
        mismatches++;
      end
      if (got.addr !== e.addr) begin
        $display("%0t: byte_address expected %0d got %0d", $time, e.addr, got.addr);
        mismatches++;
      end
      if (got.value !== e.value) begin
        $display("%0t: byte_value expected %0d got %0d", $time, e.value, got.value);
        mismatches++;
      end
      if (got.pixel_end !== e.pixel_end) begin
        $display("%0t: last_of_pixel expected %0b got %0b", $time, e.pixel_end,
                 got.pixel_end);
        mismatches++;
      end
      if (got.frame_end !== e.frame_end) begin
        $display("%0t: last_of_frame expected %0b got %0b", $time, e.frame_end,
                 got.frame_end);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [31:0]            argb_word = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [1:0]             component;
  logic [BYTE_ADDR_W-1:0] byte_address;
  logic [7:0]             byte_value;
  logic                   last_of_pixel;
  logic                   last_of_frame;

  nv21_byte_checker board;
  bit               calm = 1'b0;
  int unsigned      hold_offs_asked = 0;
  int unsigned      hold_offs_served = 0;
  int unsigned      stall_left = 0;

  logic [31:0] corner_pixels [12] = '{
    32'h00000000, 32'hFFFFFFFF, 32'h00FF0000, 32'h0000FF00,
    32'h000000FF, 32'hFF000000, 32'h00FFFF00, 32'h00FF00FF,
    32'h0000FFFF, 32'h80808080, 32'h7F7F7F7F, 32'h01010101
  };

  argb_to_yuv420_semiplanar_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .argb_word    (argb_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .component    (component),
    .byte_address (byte_address),
    .byte_value   (byte_value),
    .last_of_pixel(last_of_pixel),
    .last_of_frame(last_of_frame)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, with an occasional long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (hold_offs_served != hold_offs_asked) begin
      hold_offs_served <= hold_offs_asked;
      out_stall        <= 1'b1;
      stall_left       <= 150;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:59]:  out_stall <= 1'b0;
        [60:95]: begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(0, 2);
        end
        default: begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(10, 30);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_byte('{comp: component, addr: byte_address, value: byte_value,
                         pixel_end: last_of_pixel, frame_end: last_of_frame});
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] random_pixel();
    logic [31:0] px;
    px = $urandom;
    if ($urandom_range(0, 9) < 3) begin
      for (int c = 0; c < 3; c++) begin
        case ($urandom_range(0, 2))
          0: px[c*8 +: 8] = 8'h00;
          1: px[c*8 +: 8] = 8'hFF;
          default: ;
        endcase
      end
    end
    return px;
  endfunction

  // Called right after a rising edge; returns at the edge of the transfer or after the gap.
  task automatic send_pixel(input logic [31:0] px);
    int unsigned gap;
    in_valid  <= 1'b1;
    argb_word <= px;
    do @(posedge clk); while (in_stall);
    board.take_pixel(px);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Always moves past at least one edge, so the next driver starts in a later step.
  task automatic end_burst();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending_bytes.size() != 0);
  endtask

  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    board.write_reg(REG_FRAME_WIDTH, w);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    board.write_reg(REG_FRAME_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // One full 4x3 frame of corner colors
    set_frame(12'd4, 12'd3);
    foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
    end_burst();

    // Width and height below range: 2x1 frame, wraps after two pixels
    set_frame(12'd0, 12'd0);
    repeat (3) send_pixel(random_pixel());
    end_burst();

    // Odd width and height above range
    set_frame(12'd7, 12'hFFF);
    repeat (4) send_pixel(random_pixel());
    end_burst();

    // Widest frame: chroma plane starts at 4M, top address bit set
    set_frame(12'hFFF, 12'd2048);
    repeat (3) send_pixel(random_pixel());
    end_burst();

    // Shrink mid-frame: column past the new width ends the row
    set_frame(12'd3, 12'd2);
    repeat (4) send_pixel(random_pixel());
    end_burst();

    for (int phase = 0; phase < 5; phase++) begin
      if ($urandom_range(0, 9) < 8) w = CFG_W'($urandom_range(1, 6) * 2);
      else w = CFG_W'($urandom_range(0, 13));
      h = CFG_W'($urandom_range(1, 6));
      if (phase != 1) set_frame(w, h);  // phase 1 keeps counters and size
      calm = (phase == 2 || phase == 3);
      if (phase == 3) hold_offs_asked++;
      repeat (20) send_pixel(random_pixel());
      end_burst();
      calm = 1'b0;
    end

    repeat (10) @(posedge clk);
    if (board.mismatches == 0 && board.pending_bytes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
